// ===== sv/md5_pkg.sv =====
// Shared types, round constants and index helpers for the MD5 digest block.
// No dependencies; used by md5_message_digest_top.
package md5_pkg;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
  } md5_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL
  } md5_state_t;

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS      = 64;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [2:0]  FULL_COUNT  = 3'd4;

  localparam logic [31:0] INIT_VEC [4] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
  };

  localparam logic [31:0] SINE_TAB [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a given round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] n;
    n = rnd[3:0];
    unique case (rnd[5:4])
      2'd0:    msg_index = n;
      2'd1:    msg_index = 4'(5 * n + 1);
      2'd2:    msg_index = 4'(3 * n + 5);
      default: msg_index = 4'(7 * n);
    endcase
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    rot_amount = ROT_TAB[{rnd[5:4], rnd[1:0]}];
  endfunction

endpackage

// ===== sv/md5_message_digest_top.sv =====
// MD5 digest engine: 16-word block memory, one compression round per cycle.
// Depends on md5_pkg.
// Flow: a word that does not close a block is written without a stall; a word that closes a
// block stalls input through operand load, 64 rounds and chain update; the round loop
// reads one block word per cycle from the memory. The last word adds padding and one or
// two compressions before the digest.
// Reset (synchronous, rst_n low): chain returns to the initial vector, counters clear;
// the block memory is not cleared, every entry is written before a compression reads it.
module md5_message_digest_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  md5_pkg::md5_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output md5_pkg::md5_out_t out_data
);

  md5_pkg::md5_state_t state_r, state_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic [60:0]         total_r, total_nxt;
  logic                fin_r, fin_nxt;
  logic                need80_r, need80_nxt;
  logic                lo_done_r, lo_done_nxt;
  logic                hi_done_r, hi_done_nxt;
  logic [5:0]          round_r, round_nxt;
  logic [31:0]         chain_r [4];
  logic [31:0]         chain_nxt [4];
  logic [31:0]         rs_r [4];
  logic [31:0]         rs_nxt [4];
  logic                out_valid_r, out_valid_nxt;
  md5_pkg::md5_out_t   out_r, out_nxt;

  // block memory
  logic [31:0] blk_mem [md5_pkg::BLOCK_WORDS];
  logic        mem_we;
  logic [3:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data_r;

  // round datapath
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [31:0] rot;
  logic [2:0]  cnt;
  logic [31:0] last_wdata;
  logic [63:0] bit_len;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= blk_mem[rd_addr];
  end

  always_comb begin
    unique case (round_r[5:4])
      2'd0:    f_val = (rs_r[1] & rs_r[2]) | (~rs_r[1] & rs_r[3]);
      2'd1:    f_val = (rs_r[1] & rs_r[3]) | (rs_r[2] & ~rs_r[3]);
      2'd2:    f_val = rs_r[1] ^ rs_r[2] ^ rs_r[3];
      default: f_val = rs_r[2] ^ (rs_r[1] | ~rs_r[3]);
    endcase
    sum = rs_r[0] + f_val + rd_data_r + md5_pkg::SINE_TAB[round_r];
    dbl = {sum, sum} << md5_pkg::rot_amount(round_r);
    rot = dbl[63:32];
  end

  always_comb begin
    cnt = (in_data.byte_count > md5_pkg::FULL_COUNT) ? md5_pkg::FULL_COUNT
                                                     : in_data.byte_count;
    case (cnt)
      3'd0:    last_wdata = {24'h0, md5_pkg::PAD_BYTE};
      3'd1:    last_wdata = {16'h0, md5_pkg::PAD_BYTE, in_data.message_word[7:0]};
      3'd2:    last_wdata = {8'h0, md5_pkg::PAD_BYTE, in_data.message_word[15:0]};
      3'd3:    last_wdata = {md5_pkg::PAD_BYTE, in_data.message_word[23:0]};
      default: last_wdata = in_data.message_word;
    endcase
    bit_len = {total_r, 3'b000};
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    fin_nxt       = fin_r;
    need80_nxt    = need80_r;
    lo_done_nxt   = lo_done_r;
    hi_done_nxt   = hi_done_r;
    round_nxt     = round_r;
    chain_nxt     = chain_r;
    rs_nxt        = rs_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = '0;
    rd_addr       = md5_pkg::msg_index(round_r + 6'd1);
    in_stall      = 1'b1;

    unique case (state_r)
      md5_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          mem_we  = 1'b1;
          pos_nxt = pos_r + 4'd1;
          if (!in_data.last_word) begin
            mem_wdata = in_data.message_word;
            total_nxt = total_r + 61'd4;
          end else begin
            mem_wdata   = last_wdata;
            total_nxt   = total_r + 61'(cnt);
            need80_nxt  = (cnt == md5_pkg::FULL_COUNT);
            fin_nxt     = 1'b1;
            lo_done_nxt = 1'b0;
            hi_done_nxt = 1'b0;
            state_nxt   = md5_pkg::ST_PAD;
          end
          if (pos_r == 4'd15) begin
            state_nxt = md5_pkg::ST_LOAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        mem_we  = 1'b1;
        pos_nxt = pos_r + 4'd1;
        if (need80_r) begin
          mem_wdata  = {24'h0, md5_pkg::PAD_BYTE};
          need80_nxt = 1'b0;
        end else if (pos_r == 4'd14) begin
          mem_wdata   = bit_len[31:0];
          lo_done_nxt = 1'b1;
        end else if (pos_r == 4'd15 && lo_done_r) begin
          mem_wdata   = bit_len[63:32];
          hi_done_nxt = 1'b1;
        end
        if (pos_r == 4'd15) begin
          state_nxt = md5_pkg::ST_LOAD;
        end
      end
      md5_pkg::ST_LOAD: begin
        rd_addr   = md5_pkg::msg_index(6'd0);
        round_nxt = 6'd0;
        rs_nxt    = chain_r;
        state_nxt = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        rs_nxt[0] = rs_r[3];
        rs_nxt[1] = rs_r[1] + rot;
        rs_nxt[2] = rs_r[1];
        rs_nxt[3] = rs_r[2];
        round_nxt = round_r + 6'd1;
        if (round_r == 6'(md5_pkg::ROUNDS - 1)) begin
          state_nxt = md5_pkg::ST_FINAL;
        end
      end
      md5_pkg::ST_FINAL: begin
        if (!fin_r || !hi_done_r) begin
          for (int k = 0; k < 4; k++) begin
            chain_nxt[k] = chain_r[k] + rs_r[k];
          end
          state_nxt = fin_r ? md5_pkg::ST_PAD : md5_pkg::ST_IDLE;
        end else if (out_free) begin
          // hand off the digest and start over from the initial vector
          out_nxt.digest_a = chain_r[0] + rs_r[0];
          out_nxt.digest_b = chain_r[1] + rs_r[1];
          out_nxt.digest_c = chain_r[2] + rs_r[2];
          out_nxt.digest_d = chain_r[3] + rs_r[3];
          out_valid_nxt    = 1'b1;
          chain_nxt        = md5_pkg::INIT_VEC;
          total_nxt        = '0;
          pos_nxt          = '0;
          fin_nxt          = 1'b0;
          hi_done_nxt      = 1'b0;
          lo_done_nxt      = 1'b0;
          state_nxt        = md5_pkg::ST_IDLE;
        end
      end
      default: state_nxt = md5_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= md5_pkg::ST_IDLE;
      pos_r       <= '0;
      total_r     <= '0;
      fin_r       <= 1'b0;
      need80_r    <= 1'b0;
      lo_done_r   <= 1'b0;
      hi_done_r   <= 1'b0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      chain_r     <= md5_pkg::INIT_VEC;
      for (int k = 0; k < 4; k++) begin
        rs_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      need80_r    <= need80_nxt;
      lo_done_r   <= lo_done_nxt;
      hi_done_r   <= hi_done_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
      chain_r     <= chain_nxt;
      rs_r        <= rs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a compression always starts on a fresh block
  a_load_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == md5_pkg::ST_LOAD |-> pos_r == 4'd0)
    else $error("compression started on a partial block");

  a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == md5_pkg::ST_ROUND && round_r == 6'(md5_pkg::ROUNDS - 1))
      |=> state_r == md5_pkg::ST_FINAL)
    else $error("round loop did not end after the last round");

  a_digest_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == md5_pkg::ST_FINAL && $past(hi_done_r)))
    else $error("digest raised without a finished padded block");

  a_pad_before_length: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == md5_pkg::ST_PAD |-> (fin_r && !hi_done_r))
    else $error("padding outside a message end");

endmodule
